// File: rtl/ruas_pkg.sv
// shared constants, controller states and command/status structs
// for the rectangle union area sweep block; no dependencies
package ruas_pkg;

    localparam int DEF_Y_CELLS = 65536;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] AREA_MAX = 32'hFFFF_FFFF;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_MUL   = 10'b00_0000_0100,
        S_SUM   = 10'b00_0000_1000,
        S_TOP   = 10'b00_0001_0000,
        S_RDL   = 10'b00_0010_0000,
        S_RDR   = 10'b00_0100_0000,
        S_WR    = 10'b00_1000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_ENTER = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2
    } phase_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mul;
        logic sum;
        logic start;
        logic push_left;
        logic push_right;
        logic rd_apply;
        logic rd_plain;
        logic cap_node;
        logic rd_left;
        logic cap_left;
        logic rd_right;
        logic wr_node;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic   clr_done;
        logic   walk_empty;
        logic   out_free;
        phase_t top_ph;
        logic   top_disjoint;
        logic   top_cover;
        logic   top_leaf;
        logic   last_frame;
    } status_t;

endpackage

// File: rtl/ruas_in_if.sv
// input channel of the sweep block: one edge event per item
// depends on nothing
interface ruas_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] edge_x;
    logic [15:0] y_low;
    logic [15:0] y_high;
    logic        func;
    logic        first_event;

    modport source (output valid, edge_x, y_low, y_high, func, first_event, input ready);
    modport sink (input valid, edge_x, y_low, y_high, func, first_event, output ready);
endinterface

// File: rtl/ruas_out_if.sv
// output channel of the sweep block: running area per item
// depends on nothing
interface ruas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] area;
    logic        order_error;

    modport source (output valid, area, order_error, input ready);
    modport sink (input valid, area, order_error, output ready);
endinterface

// File: rtl/rectangle_union_area_sweep.sv
// top level of the rectangle union area sweep over a segment tree of y cells
// depends on ruas_pkg, ruas_in_if, ruas_out_if, ruas_ctrl, ruas_dp
//
//  channel   dir   payload                                   handshake
//  in_ch     in    edge_x, y_low, y_high, func, first_event  valid/ready
//  out_ch    out   area, order_error                         valid/ready
//
// one item at a time: an area update (load, multiply, sum), then for a nonempty
// interval a walk over the tree nodes that the range meets (one memory port, registered read)
// after reset a clearing pass writes all 4*Y_CELLS nodes, one a cycle, with in_ch held off
// a result waits in the output register; a stalled output holds only the next area update
module rectangle_union_area_sweep #(
    parameter int Y_CELLS = ruas_pkg::DEF_Y_CELLS
) (
    input  logic       clk,
    input  logic       rst_n,
    ruas_in_if.sink    in_ch,
    ruas_out_if.source out_ch
);

    ruas_pkg::cmd_t    cmd;
    ruas_pkg::status_t st;

    ruas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ruas_dp #(
        .Y_CELLS (Y_CELLS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .st     (st)
    );

endmodule

// File: rtl/ruas_ctrl.sv
// sequencer of the sweep block: clearing pass, area update, tree walk
// depends on ruas_pkg
module ruas_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ruas_pkg::status_t st,
    output ruas_pkg::cmd_t    cmd
);

    ruas_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ruas_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ruas_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_done)
                begin
                    state_next = ruas_pkg::S_IDLE;
                end
            end
            ruas_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ruas_pkg::S_MUL;
                end
            end
            ruas_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ruas_pkg::S_SUM;
            end
            ruas_pkg::S_SUM:
            begin
                if (st.out_free)
                begin
                    cmd.sum = 1'b1;
                    if (st.walk_empty)
                    begin
                        state_next = ruas_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        state_next = ruas_pkg::S_TOP;
                    end
                end
            end
            ruas_pkg::S_TOP:
            begin
                case (st.top_ph)
                    ruas_pkg::PH_ENTER:
                    begin
                        if (st.top_disjoint)
                        begin
                            cmd.pop = 1'b1;
                            state_next = st.last_frame ? ruas_pkg::S_IDLE : ruas_pkg::S_TOP;
                        end
                        else if (st.top_cover)
                        begin
                            cmd.rd_apply = 1'b1;
                            state_next = ruas_pkg::S_RDL;
                        end
                        else
                        begin
                            cmd.push_left = 1'b1;
                        end
                    end
                    ruas_pkg::PH_LEFT:
                    begin
                        cmd.push_right = 1'b1;
                    end
                    default:
                    begin
                        cmd.rd_plain = 1'b1;
                        state_next = ruas_pkg::S_RDL;
                    end
                endcase
            end
            ruas_pkg::S_RDL:
            begin
                cmd.cap_node = 1'b1;
                if (st.top_leaf)
                begin
                    state_next = ruas_pkg::S_WR;
                end
                else
                begin
                    cmd.rd_left = 1'b1;
                    state_next = ruas_pkg::S_RDR;
                end
            end
            ruas_pkg::S_RDR:
            begin
                cmd.cap_left = 1'b1;
                cmd.rd_right = 1'b1;
                state_next = ruas_pkg::S_WR;
            end
            ruas_pkg::S_WR:
            begin
                cmd.wr_node = 1'b1;
                cmd.pop = 1'b1;
                state_next = st.last_frame ? ruas_pkg::S_IDLE : ruas_pkg::S_TOP;
            end
            default:
            begin
                state_next = ruas_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/ruas_dp.sv
// datapath of the sweep block: node memory, walk stack, area arithmetic
// depends on ruas_pkg, ruas_in_if, ruas_out_if
module ruas_dp #(
    parameter int Y_CELLS = ruas_pkg::DEF_Y_CELLS
) (
    input  logic              clk,
    input  logic              rst_n,
    ruas_in_if.sink           in_ch,
    ruas_out_if.source        out_ch,
    input  ruas_pkg::cmd_t    cmd,
    output ruas_pkg::status_t st
);

    localparam int CW = $clog2(Y_CELLS);
    localparam int LEN_W = $clog2(Y_CELLS + 1);
    localparam int NODE_COUNT = 4 * Y_CELLS;
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int QW = ((CW > 16) ? CW : 16) + 1;
    localparam int MW = 16 + LEN_W;
    localparam int PW = 16 + LEN_W;
    localparam int SW = ((PW > 32) ? PW : 32) + 1;
    localparam int STK = CW + 1;
    localparam int SP_W = $clog2(STK + 1);
    localparam int IDX_W = $clog2(STK);
    localparam logic [QW-1:0] Y_LIMIT = QW'(Y_CELLS);
    localparam logic [CW-1:0] Y_LAST = CW'(Y_CELLS - 1);
    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);

    logic [MW-1:0] mem [NODE_COUNT];
    logic [MW-1:0] rdata_reg;

    logic [15:0]   x_reg, prev_x_reg;
    logic [QW-1:0] qlo_reg, qhi_reg;
    logic          closing_reg, first_reg, err_reg;
    logic [31:0]   area_reg;
    logic [PW-1:0] prod_reg;
    logic [LEN_W-1:0] root_len_reg;
    logic          out_valid_reg;
    logic [31:0]   out_area_reg;
    logic          out_err_reg;
    logic [NODE_W-1:0] clr_addr_reg;

    logic [NODE_W-1:0] stk_node [STK];
    logic [CW-1:0]     stk_lo [STK];
    logic [CW-1:0]     stk_hi [STK];
    ruas_pkg::phase_t  stk_ph [STK];
    logic [SP_W-1:0]   sp_reg;

    logic          apply_reg;
    logic [15:0]   cnt_reg;
    logic [LEN_W-1:0] left_len_reg;

    logic [IDX_W-1:0]  tp, np;
    logic [NODE_W-1:0] t_node, t_lchild, t_rchild;
    logic [CW-1:0]     t_lo, t_hi, t_mid;
    logic [QW-1:0]     t_lo_q, t_hi_q;
    logic [LEN_W-1:0]  t_span, new_len, child_sum;
    logic [15:0]       upd_cnt, rd_cnt;
    logic [LEN_W-1:0]  rd_len;
    logic [QW-1:0]     yhi_clip;
    logic [SW-1:0]     sum_wide;
    logic [NODE_W-1:0] rd_addr;
    logic              rd_en;

    assign tp = IDX_W'(sp_reg - SP_W'(1));
    assign np = sp_reg[IDX_W-1:0];
    assign t_node = stk_node[tp];
    assign t_lo = stk_lo[tp];
    assign t_hi = stk_hi[tp];
    assign t_lo_q = QW'(t_lo);
    assign t_hi_q = QW'(t_hi);
    assign t_mid = t_lo + ((t_hi - t_lo) >> 1);
    assign t_lchild = {t_node[NODE_W-2:0], 1'b0};
    assign t_rchild = {t_node[NODE_W-2:0], 1'b1};
    assign t_span = LEN_W'(t_hi - t_lo) + LEN_W'(1);

    assign rd_cnt = rdata_reg[MW-1:LEN_W];
    assign rd_len = rdata_reg[LEN_W-1:0];

    // cover count step, held at zero and at the top
    always_comb
    begin
        upd_cnt = rd_cnt;
        if (closing_reg)
        begin
            if (rd_cnt != 16'd0)
            begin
                upd_cnt = rd_cnt - 16'd1;
            end
        end
        else if (rd_cnt != ruas_pkg::COUNT_MAX)
        begin
            upd_cnt = rd_cnt + 16'd1;
        end
    end

    assign child_sum = left_len_reg + rd_len;
    always_comb
    begin
        if (cnt_reg != 16'd0)
        begin
            new_len = t_span;
        end
        else if (t_lo == t_hi)
        begin
            new_len = '0;
        end
        else
        begin
            new_len = child_sum;
        end
    end

    assign yhi_clip = (QW'(in_ch.y_high) > Y_LIMIT) ? Y_LIMIT : QW'(in_ch.y_high);
    assign sum_wide = SW'(area_reg) + SW'(prod_reg);

    always_comb
    begin
        rd_en = cmd.rd_apply | cmd.rd_plain | cmd.rd_left | cmd.rd_right;
        if (cmd.rd_left)
        begin
            rd_addr = t_lchild;
        end
        else if (cmd.rd_right)
        begin
            rd_addr = t_rchild;
        end
        else
        begin
            rd_addr = t_node;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.wr_node)
        begin
            mem[t_node] <= {cnt_reg, new_len};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // walk stack and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            stk_node[0] <= NODE_W'(1);
            stk_lo[0] <= '0;
            stk_hi[0] <= Y_LAST;
            stk_ph[0] <= ruas_pkg::PH_ENTER;
        end
        if (cmd.push_left)
        begin
            stk_ph[tp] <= ruas_pkg::PH_LEFT;
            stk_node[np] <= t_lchild;
            stk_lo[np] <= t_lo;
            stk_hi[np] <= t_mid;
            stk_ph[np] <= ruas_pkg::PH_ENTER;
        end
        if (cmd.push_right)
        begin
            stk_ph[tp] <= ruas_pkg::PH_RIGHT;
            stk_node[np] <= t_rchild;
            stk_lo[np] <= t_mid + CW'(1);
            stk_hi[np] <= t_hi;
            stk_ph[np] <= ruas_pkg::PH_ENTER;
        end
        if (cmd.rd_apply)
        begin
            apply_reg <= 1'b1;
        end
        else if (cmd.rd_plain)
        begin
            apply_reg <= 1'b0;
        end
        if (cmd.cap_node)
        begin
            cnt_reg <= apply_reg ? upd_cnt : rd_cnt;
        end
        if (cmd.cap_left)
        begin
            left_len_reg <= rd_len;
        end
        if (cmd.load)
        begin
            x_reg <= in_ch.edge_x;
            qlo_reg <= QW'(in_ch.y_low);
            qhi_reg <= yhi_clip;
            closing_reg <= in_ch.func;
            first_reg <= in_ch.first_event;
        end
        if (cmd.mul)
        begin
            err_reg <= !first_reg && (x_reg < prev_x_reg);
            prod_reg <= PW'(x_reg - prev_x_reg) * PW'(root_len_reg);
        end
        if (cmd.sum)
        begin
            out_err_reg <= err_reg;
            out_area_reg <= first_reg ? 32'd0 : err_reg ? area_reg :
                            (sum_wide > SW'(ruas_pkg::AREA_MAX)) ? ruas_pkg::AREA_MAX :
                            sum_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            clr_addr_reg <= '0;
            prev_x_reg <= '0;
            area_reg <= '0;
            root_len_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + NODE_W'(1);
            end
            if (cmd.start)
            begin
                sp_reg <= SP_W'(1);
            end
            else if (cmd.push_left || cmd.push_right)
            begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_reg - SP_W'(1);
            end
            if (cmd.wr_node && t_node == NODE_W'(1))
            begin
                root_len_reg <= new_len;
            end
            if (cmd.sum)
            begin
                prev_x_reg <= x_reg;
                area_reg <= first_reg ? 32'd0 : err_reg ? area_reg :
                            (sum_wide > SW'(ruas_pkg::AREA_MAX)) ? ruas_pkg::AREA_MAX :
                            sum_wide[31:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.area = out_area_reg;
    assign out_ch.order_error = out_err_reg;

    assign st.clr_done = (clr_addr_reg == NODE_LAST);
    assign st.walk_empty = !(qlo_reg < qhi_reg);
    assign st.out_free = !out_valid_reg || out_ch.ready;
    assign st.top_ph = stk_ph[tp];
    assign st.top_disjoint = (t_lo_q >= qhi_reg) || (t_hi_q < qlo_reg);
    assign st.top_cover = (qlo_reg <= t_lo_q) && (t_hi_q < qhi_reg);
    assign st.top_leaf = (t_lo == t_hi);
    assign st.last_frame = (sp_reg == SP_W'(1));

endmodule
